// ----- hw/rtl/cce_pkg.sv -----
// ----------------------------------------------------------------------------
// cce_pkg
// shared types, register indexes and crc helper functions for the crc engine
// ----------------------------------------------------------------------------
package cce_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLYNOMIAL    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFLECT_IN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFLECT_OUT   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_VALUE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_XOR_OUT       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_APPEND_LENGTH = 3'd5;

   localparam logic [31:0] POLYNOMIAL_RESET  = 32'h04C1_1DB7;
   localparam logic [31:0] START_VALUE_RESET = 32'hFFFF_FFFF;
   localparam logic [31:0] XOR_OUT_RESET     = 32'hFFFF_FFFF;

   localparam logic ACTION_DATA   = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   typedef struct packed {
      logic [31:0] polynomial;
      logic        reflect_in;
      logic        reflect_out;
      logic [31:0] start_value;
      logic [31:0] xor_out;
      logic        append_length;
   } cfg_type;

   typedef struct packed {
      logic absorb;      // fold one byte into the crc register
      logic sel_length;  // byte comes from the length shifter
      logic count_inc;   // saturating byte count increment
      logic len_load;    // load length shifter from byte count
      logic len_shift;   // drop the low length byte
      logic emit;        // load result register and restart message
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic len_last;
      logic out_free;
   } status_type;

   function automatic logic [7:0] bit_rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [31:0] bit_rev32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = v[31-i];
      end
      return r;
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [7:0]  data,
                                            input logic [31:0] rpoly,
                                            input logic        refl_in);
      logic [7:0]  b;
      logic [31:0] c;
      b = refl_in ? data : bit_rev8(data);
      c = crc ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         c = {1'b0, c[31:1]} ^ (c[0] ? rpoly : 32'h0);
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/configurable_crc32_engine.sv -----
// ----------------------------------------------------------------------------
// configurable_crc32_engine
// rocksoft-style crc-32 over a byte stream with optional cksum length suffix
// ----------------------------------------------------------------------------
// A data transaction is absorbed in the cycle it is accepted, so bytes stream in
// at one per cycle. A finish holds the request side while the significant bytes
// of the byte count go in when length append is on (at most ceil(LENGTH_BITS/8)),
// one byte per cycle through the single byte-wide crc update, and while the
// result is emitted, which waits only while the previous result still sits
// unaccepted in the output register. Data for the next message is accepted while
// a result waits. Configuration writes must come while idle (not enforced).
module configurable_crc32_engine
   import cce_pkg::*;
#(
   parameter int LENGTH_BITS = 64
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [31:0]               rsp_crc_value,
   output logic [63:0]               rsp_byte_count,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       start_wr;

   cce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .start_wr  (start_wr)
   );

   cce_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_action    (req_action),
      .req_stall     (req_stall),
      .append_length (cfg.append_length),
      .status        (status),
      .cmd           (cmd)
   );

   cce_datapath #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_data_byte),
      .cfg            (cfg),
      .start_wr       (start_wr),
      .start_data     (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crc_value  (rsp_crc_value),
      .rsp_byte_count (rsp_byte_count)
   );

endmodule

// ----- hw/rtl/cce_csr.sv -----
// ----------------------------------------------------------------------------
// cce_csr
// configuration registers of the crc engine, written through a plain port
// ----------------------------------------------------------------------------
module cce_csr
   import cce_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg,
   output logic                      start_wr
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLYNOMIAL:    cfg_in.polynomial    = csr_wdata;
            CSR_REFLECT_IN:    cfg_in.reflect_in    = csr_wdata[0];
            CSR_REFLECT_OUT:   cfg_in.reflect_out   = csr_wdata[0];
            CSR_START_VALUE:   cfg_in.start_value   = csr_wdata;
            CSR_XOR_OUT:       cfg_in.xor_out       = csr_wdata;
            CSR_APPEND_LENGTH: cfg_in.append_length = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial    <= POLYNOMIAL_RESET;
         cfg_ff.reflect_in    <= 1'b1;
         cfg_ff.reflect_out   <= 1'b1;
         cfg_ff.start_value   <= START_VALUE_RESET;
         cfg_ff.xor_out       <= XOR_OUT_RESET;
         cfg_ff.append_length <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg      = cfg_ff;
   assign start_wr = csr_we && (csr_index == CSR_START_VALUE);

endmodule

// ----- hw/rtl/cce_ctrl.sv -----
// ----------------------------------------------------------------------------
// cce_ctrl
// sequencer for data bytes, length suffix and result hand-off
// ----------------------------------------------------------------------------
module cce_ctrl
   import cce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_stall,
   input  logic       append_length,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_APPEND = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_RUN: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACTION_DATA) begin
                  cmd.absorb    = 1'b1;
                  cmd.count_inc = 1'b1;
               end else if (append_length && !status.count_zero) begin
                  cmd.len_load = 1'b1;
                  state_in     = ST_APPEND;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_APPEND: begin
            cmd.absorb     = 1'b1;
            cmd.sel_length = 1'b1;
            cmd.len_shift  = 1'b1;
            if (status.len_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/cce_datapath.sv -----
// ----------------------------------------------------------------------------
// cce_datapath
// crc register, byte counter, length shifter and result register
// ----------------------------------------------------------------------------
module cce_datapath
   import cce_pkg::*;
#(
   parameter int LENGTH_BITS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  cfg_type     cfg,
   input  logic        start_wr,
   input  logic [31:0] start_data,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_crc_value,
   output logic [63:0] rsp_byte_count
);

   logic [31:0]            crc_ff;
   logic [31:0]            crc_in;
   logic [LENGTH_BITS-1:0] count_ff;
   logic [LENGTH_BITS-1:0] count_in;
   logic [LENGTH_BITS-1:0] len_ff;
   logic [LENGTH_BITS-1:0] len_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [31:0]            rsp_crc_ff;
   logic [31:0]            rsp_crc_in;
   logic [63:0]            rsp_count_ff;
   logic [63:0]            rsp_count_in;
   logic [7:0]             byte_sel;
   logic [31:0]            crc_final;

   assign byte_sel  = cmd.sel_length ? len_ff[7:0] : req_data_byte;
   assign crc_final = cfg.reflect_out ? (crc_ff ^ cfg.xor_out)
                                      : bit_rev32(crc_ff ^ cfg.xor_out);

   always_comb begin
      crc_in       = crc_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.absorb) begin
         crc_in = crc_byte(crc_ff, byte_sel, bit_rev32(cfg.polynomial), cfg.reflect_in);
      end
      if (cmd.count_inc && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.len_load) begin
         len_in = count_ff;
      end else if (cmd.len_shift) begin
         len_in = len_ff >> 8;
      end
      if (cmd.emit) begin
         rsp_crc_in   = crc_final;
         rsp_count_in = 64'(count_ff);
         rsp_valid_in = 1'b1;
         crc_in       = cfg.start_value;
         count_in     = '0;
      end
      if (start_wr && (count_ff == '0)) begin
         crc_in = start_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= START_VALUE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      rsp_crc_ff   <= rsp_crc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.count_zero = (count_ff == '0);
   assign status.len_last   = (len_ff[LENGTH_BITS-1:8] == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_value  = rsp_crc_ff;
   assign rsp_byte_count = rsp_count_ff;

endmodule
